FILE: rtl/skcd_pkg.sv
// ----------------------------------------------------------------------------
// skcd_pkg
// Shared types, codes and helper functions of the split keyboard chord
// detector: command word passed from the front end to the sequencer,
// configuration bundle, result codes and the chord interval table.
// ----------------------------------------------------------------------------
package skcd_pkg;

	// default number of chord slots
	localparam int SLOTS_DEF = 5;
	// largest slot count the interval lookup supports
	localparam int SLOTS_MAX = 8;
	localparam int IDXF_W    = $clog2(SLOTS_MAX);

	// command queue depth between front end and sequencer
	localparam int Q_DEPTH = 2;

	// stream and config port widths
	localparam int S_DATA_W   = 24;
	localparam int M_DATA_W   = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	// config register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHORD_ACTIVE  = 3'd0,
		CFG_ACCOMP_MODE   = 3'd1,
		CFG_RIGHT_OVERLAY = 3'd2,
		CFG_SPLIT_KEY     = 3'd3,
		CFG_HOLD_TICKS    = 3'd4
	} cfg_idx_t;

	// config reset values
	localparam logic [6:0] SPLIT_KEY_RST  = 7'd60;
	localparam logic [3:0] HOLD_TICKS_RST = 4'd5;

	// status byte codes
	localparam logic [7:0] STAT_SYS_A   = 8'd120;
	localparam logic [7:0] STAT_SYS_B   = 8'd126;
	localparam logic [7:0] STAT_NOTE_C2 = 8'h11;
	localparam logic [3:0] CHAN_1       = 4'h1;
	localparam logic [3:0] CHAN_2       = 4'h2;
	localparam logic [2:0] CMD_RELEASE  = 3'd0;
	localparam logic [2:0] CMD_PRESS    = 3'd1;

	// result kinds (travel on tuser)
	typedef enum logic [1:0] {
		RK_NOTE  = 2'd0,
		RK_IND   = 2'd1,
		RK_CHORD = 2'd2
	} rk_t;

	// indicator tags
	localparam logic [2:0] TAG_KEY   = 3'd2;
	localparam logic [2:0] TAG_CHORD = 3'd4;

	// chord type codes and interval table rows
	localparam logic [6:0] CT_MAJ  = 7'd0;
	localparam logic [6:0] CT_MIN  = 7'd8;
	localparam logic [6:0] CT_MIN7 = 7'd10;
	localparam logic [6:0] CT_SEV  = 7'd19;

	localparam logic [1:0] ROW_MAJ  = 2'd0;
	localparam logic [1:0] ROW_MIN  = 2'd1;
	localparam logic [1:0] ROW_MIN7 = 2'd2;
	localparam logic [1:0] ROW_SEV  = 2'd3;

	localparam int IV_COLS = 5;
	localparam logic [3:0] INTERVALS [4][IV_COLS] = '{
		'{4'd0, 4'd4, 4'd7, 4'd0,  4'd0},
		'{4'd0, 4'd3, 4'd7, 4'd0,  4'd0},
		'{4'd0, 4'd3, 4'd7, 4'd10, 4'd0},
		'{4'd0, 4'd4, 4'd7, 4'd10, 4'd0}
	};

	// front end classification
	typedef enum logic [2:0] {
		OP_RIGHT,
		OP_LPASS,
		OP_LMUTE,
		OP_LCHORD,
		OP_TICK
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] status;
		logic [6:0] key;
		logic [6:0] vel;
	} cmd_t;

	typedef struct packed {
		logic       chord_active;
		logic       accomp_mode;
		logic       right_overlay;
		logic [6:0] split_key;
		logic [3:0] hold_ticks;
	} cfg_t;

	// interval of a chord row at a slot position, zero past the table
	function automatic logic [3:0] interval(input logic [1:0] row, input logic [IDXF_W-1:0] i);
		logic [3:0] iv;
		iv = 4'd0;
		if (i < IDXF_W'(IV_COLS))
			iv = INTERVALS[row][i[2:0]];
		return iv;
	endfunction

	// key code mod 12, reciprocal multiply plus one correction
	function automatic logic [3:0] pitch_class(input logic [6:0] code);
		logic [12:0] prod;
		logic [3:0]  q;
		logic [6:0]  r;
		prod = 13'(code) * 13'd43;
		q    = prod[12:9];
		r    = code - 7'({3'b000, q} * 7'd12);
		if (r >= 7'd12)
			r = r - 7'd12;
		return r[3:0];
	endfunction

	function automatic logic black_key(input logic [6:0] code);
		logic [3:0] pc;
		logic       blk;
		pc = pitch_class(code);
		case (pc) inside
			4'd1, 4'd3, 4'd6, 4'd8, 4'd10: blk = 1'b1;
			default: blk = 1'b0;
		endcase
		return blk;
	endfunction

endpackage

FILE: rtl/split_keyboard_chord_detector.sv
// ----------------------------------------------------------------------------
// split_keyboard_chord_detector
// Split keyboard with one-finger chord detection and key indicators.
// ----------------------------------------------------------------------------
// Input words are classified on arrival and parked in a two-entry command
// queue; a sequencer behind it executes one command at a time and emits at
// most one result word per clock through a registered output, holding while
// the output stalls, so input keeps flowing while a result waits. Config
// writes must happen while the block is idle.
// ----------------------------------------------------------------------------
module split_keyboard_chord_detector #(
	parameter int SLOTS = skcd_pkg::SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [skcd_pkg::S_DATA_W-1:0]   s_tdata,   // status[7:0], key_code[14:8],
	                                                   // velocity[21:15]
	input  logic                            s_tuser,   // kind
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [skcd_pkg::M_DATA_W-1:0]   m_tdata,   // out_status[7:0], out_note[15:8],
	                                                   // out_value[22:16], lit[23],
	                                                   // indicator_tag[26:24]
	output logic [1:0]                      m_tuser,   // result_kind
	output logic                            m_tlast,
	// config write port
	input  logic                            cfg_we,
	input  logic [skcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [skcd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import skcd_pkg::*;

	cfg_t cfg_q;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	cmd_t wr_cmd;
	cmd_t rd_cmd;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chord_active  <= 1'b0;
			cfg_q.accomp_mode   <= 1'b0;
			cfg_q.right_overlay <= 1'b0;
			cfg_q.split_key     <= SPLIT_KEY_RST;
			cfg_q.hold_ticks    <= HOLD_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHORD_ACTIVE:  cfg_q.chord_active  <= cfg_data[0];
				CFG_ACCOMP_MODE:   cfg_q.accomp_mode   <= cfg_data[0];
				CFG_RIGHT_OVERLAY: cfg_q.right_overlay <= cfg_data[0];
				CFG_SPLIT_KEY:     cfg_q.split_key     <= cfg_data[6:0];
				CFG_HOLD_TICKS:    cfg_q.hold_ticks    <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	skcd_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.push     (push),
		.cmd      (wr_cmd)
	);

	skcd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.full   (q_full),
		.empty  (q_empty)
	);

	skcd_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (rd_cmd),
		.q_empty  (q_empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: rtl/skcd_front.sv
// ----------------------------------------------------------------------------
// skcd_front
// Input side: accepts words, drops the ones that can cause no result and turns
// the rest into a command for the sequencer queue.
// ----------------------------------------------------------------------------
module skcd_front (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [skcd_pkg::S_DATA_W-1:0] s_tdata,  // status[7:0], key_code[14:8], velocity[21:15]
	input  logic                          s_tuser,  // kind
	input  skcd_pkg::cfg_t                cfg,
	input  logic                          q_full,
	output logic                          push,
	output skcd_pkg::cmd_t                cmd
);
	import skcd_pkg::*;

	logic [7:0] status;
	logic [6:0] key;
	logic [6:0] vel;
	logic       reset_like;
	logic       note_cmd;
	logic       keep;

	assign status = s_tdata[7:0];
	assign key    = s_tdata[14:8];
	assign vel    = s_tdata[21:15];

	// queue takes a word whenever it has room
	assign s_tready = !q_full;

	// classify the word
	always_comb begin
		reset_like = (status == STAT_SYS_A || status == STAT_SYS_B) &&
			key == 7'd0 && vel == 7'd0;
		note_cmd   = status[6:4] == CMD_RELEASE || status[6:4] == CMD_PRESS;
		cmd.status = status;
		cmd.key    = key;
		cmd.vel    = vel;
		cmd.op     = OP_TICK;
		keep       = 1'b0;
		if (s_tuser) begin
			// ticks matter only to the chord generator
			keep = cfg.chord_active;
		end else begin
			keep = !reset_like && note_cmd;
			if (key < cfg.split_key) begin
				if (cfg.chord_active)
					cmd.op = OP_LCHORD;
				else if (cfg.accomp_mode)
					cmd.op = OP_LMUTE;
				else
					cmd.op = OP_LPASS;
			end else begin
				cmd.op = OP_RIGHT;
			end
		end
	end

	assign push = s_tvalid && s_tready && keep;

endmodule

FILE: rtl/skcd_fifo.sv
// ----------------------------------------------------------------------------
// skcd_fifo
// Short command queue between front end and sequencer.
// ----------------------------------------------------------------------------
module skcd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  skcd_pkg::cmd_t wr_cmd,
	input  logic           pop,
	output skcd_pkg::cmd_t rd_cmd,
	output logic           full,
	output logic           empty
);
	import skcd_pkg::*;

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);

	cmd_t          mem_q [Q_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full   = count_q == CW'(Q_DEPTH);
	assign empty  = count_q == '0;
	assign rd_cmd = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != CW'(Q_DEPTH))
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("command queue underflow");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count lost a push");

endmodule

FILE: rtl/skcd_back.sv
// ----------------------------------------------------------------------------
// skcd_back
// Sequencer: owns chord slots, held velocity and countdown, and executes one
// command at a time, producing at most one result word per clock into the
// output register, and holding while the output stalls.
// ----------------------------------------------------------------------------
module skcd_back #(
	parameter int SLOTS = skcd_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  skcd_pkg::cfg_t                cfg,
	input  skcd_pkg::cmd_t                cmd,
	input  logic                          q_empty,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [skcd_pkg::M_DATA_W-1:0] m_tdata,  // out_status[7:0], out_note[15:8],
	                                                // out_value[22:16], lit[23],
	                                                // indicator_tag[26:24]
	output logic [1:0]                    m_tuser,  // result_kind
	output logic                          m_tlast
);
	import skcd_pkg::*;

	localparam int IW = $clog2(SLOTS);

	typedef enum logic [3:0] {
		S_IDLE,
		S_NOTE,
		S_OVERLAY,
		S_KEYIND,
		S_CHORD_KEY,
		S_REL,
		S_TICK,
		S_SORT,
		S_CLASS,
		S_VOICE
	} state_t;

	typedef struct packed {
		rk_t        kind;
		logic [7:0] status;
		logic [7:0] note;
		logic [6:0] value;
		logic       lit;
		logic [2:0] tag;
		logic       last;
	} res_t;

	state_t        state_q;
	cmd_t          cmd_q;
	logic [7:0]    slot_q [SLOTS];
	logic [6:0]    held_vel_q;
	logic [3:0]    cnt_q;
	logic [IW-1:0] idx_q;
	logic          ph_q;
	logic [1:0]    row_q;
	res_t          res_q;
	logic          m_tvalid_q;

	logic [7:0]    slot_cur;
	logic [3:0]    iv;
	logic [7:0]    voice_v;
	logic          voice_on;
	logic          idx_end;
	logic [IW-1:0] last_idx;
	logic          free_found;
	logic [IW-1:0] free_idx;
	logic [7:0]    srt0, srt1, srt2;
	logic [1:0]    row_c;
	logic [6:0]    type_c;
	logic          em_req;
	res_t          em;
	logic          fire;
	logic          go;
	logic          press;

	assign slot_cur = slot_q[idx_q];
	assign iv       = interval(row_q, IDXF_W'(idx_q));
	assign voice_v  = slot_q[0] + {4'b0000, iv};
	assign voice_on = idx_q == '0 || iv != 4'd0;
	assign idx_end  = idx_q == IW'(SLOTS - 1);
	assign last_idx = (row_q[1] && SLOTS >= 4) ? IW'(3) : IW'(2);
	assign press    = cmd_q.vel != 7'd0 && cmd_q.status[4];

	// first empty slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!free_found && slot_q[i] == 8'd0) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	// three compare-swaps: highest key of the first three slots to the top
	always_comb begin
		logic [7:0] t;
		t    = 8'd0;
		srt0 = slot_q[0];
		srt1 = slot_q[1];
		srt2 = slot_q[2];
		if (srt0 < srt1) begin
			t = srt0; srt0 = srt1; srt1 = t;
		end
		if (srt1 < srt2) begin
			t = srt1; srt1 = srt2; srt2 = t;
		end
		if (srt0 < srt1) begin
			t = srt0; srt0 = srt1; srt1 = t;
		end
	end

	// one-finger rule on the sorted slots
	always_comb begin
		if (slot_q[1] == 8'd0) begin
			row_c = ROW_MAJ; type_c = CT_MAJ;
		end else if (slot_q[2] != 8'd0) begin
			row_c = ROW_MIN7; type_c = CT_MIN7;
		end else if (black_key(slot_q[1][6:0])) begin
			row_c = ROW_MIN; type_c = CT_MIN;
		end else begin
			row_c = ROW_SEV; type_c = CT_SEV;
		end
	end

	// result word of the current step
	always_comb begin
		em_req    = 1'b0;
		em        = '0;
		em.kind   = RK_NOTE;
		case (state_q)
			S_NOTE: begin
				em_req    = 1'b1;
				em.status = (cmd_q.op == OP_RIGHT) ? cmd_q.status : {cmd_q.status[7:4], CHAN_1};
				em.note   = {1'b0, cmd_q.key};
				em.value  = cmd_q.vel;
			end
			S_OVERLAY: begin
				em_req    = 1'b1;
				em.status = {cmd_q.status[7:4], CHAN_2};
				em.note   = {1'b0, cmd_q.key};
				em.value  = cmd_q.vel;
			end
			S_KEYIND: begin
				em_req  = 1'b1;
				em.kind = RK_IND;
				em.note = {1'b0, cmd_q.key};
				em.lit  = cmd_q.vel != 7'd0;
				em.tag  = TAG_KEY;
				em.last = 1'b1;
			end
			S_REL: begin
				if (slot_cur != 8'd0) begin
					em_req  = 1'b1;
					em.note = slot_cur;
					if (!ph_q && !cfg.accomp_mode) begin
						em.status = STAT_NOTE_C2;
					end else begin
						em.kind = RK_IND;
						em.tag  = TAG_CHORD;
					end
				end
			end
			S_CLASS: begin
				if (cfg.accomp_mode) begin
					em_req   = 1'b1;
					em.kind  = RK_CHORD;
					em.note  = {4'b0000, pitch_class(slot_q[0][6:0])};
					em.value = type_c;
				end
			end
			S_VOICE: begin
				if (voice_on) begin
					em_req  = 1'b1;
					em.note = voice_v;
					if (!ph_q && !cfg.accomp_mode) begin
						em.status = STAT_NOTE_C2;
						em.value  = held_vel_q;
					end else begin
						em.kind = RK_IND;
						em.lit  = 1'b1;
						em.tag  = TAG_CHORD;
						em.last = idx_q == last_idx;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign fire = !m_tvalid_q || m_tready;
	assign go   = !em_req || fire;
	assign pop  = state_q == S_IDLE && !q_empty;

	// sequencer, state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cmd_q      <= '0;
			for (int i = 0; i < SLOTS; i++)
				slot_q[i] <= 8'd0;
			held_vel_q <= 7'd0;
			cnt_q      <= 4'd0;
			idx_q      <= '0;
			ph_q       <= 1'b0;
			row_q      <= ROW_MAJ;
			res_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (em_req && fire) begin
				res_q      <= em;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						cmd_q <= cmd;
						unique case (cmd.op)
							OP_RIGHT, OP_LPASS: state_q <= S_NOTE;
							OP_LMUTE:           state_q <= S_KEYIND;
							OP_LCHORD:          state_q <= S_CHORD_KEY;
							default:            state_q <= S_TICK;
						endcase
					end
				end
				S_NOTE: begin
					if (go)
						state_q <= (cmd_q.op == OP_RIGHT && cfg.right_overlay) ?
							S_OVERLAY : S_KEYIND;
				end
				S_OVERLAY: begin
					if (go)
						state_q <= S_KEYIND;
				end
				S_KEYIND: begin
					if (go)
						state_q <= S_IDLE;
				end
				S_CHORD_KEY: begin
					idx_q <= '0;
					ph_q  <= 1'b0;
					if (press) begin
						held_vel_q <= cmd_q.vel;
						if (free_found) begin
							slot_q[free_idx] <= {1'b0, cmd_q.key};
							cnt_q            <= cfg.hold_ticks;
						end
						state_q <= S_KEYIND;
					end else if (slot_q[0] != 8'd0 || !cmd_q.status[4]) begin
						state_q <= S_REL;
					end else begin
						state_q <= S_KEYIND;
					end
				end
				S_REL: begin
					if (go) begin
						if (slot_cur != 8'd0 && !ph_q && !cfg.accomp_mode) begin
							ph_q <= 1'b1;
						end else begin
							ph_q          <= 1'b0;
							slot_q[idx_q] <= 8'd0;
							if (idx_end)
								state_q <= S_KEYIND;
							else
								idx_q <= idx_q + IW'(1);
						end
					end
				end
				S_TICK: begin
					if (cnt_q != 4'd0 && slot_q[0] != 8'd0) begin
						cnt_q   <= cnt_q - 4'd1;
						state_q <= (cnt_q == 4'd1) ? S_SORT : S_IDLE;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SORT: begin
					slot_q[0] <= srt0;
					slot_q[1] <= srt1;
					slot_q[2] <= srt2;
					state_q   <= S_CLASS;
				end
				S_CLASS: begin
					if (go) begin
						row_q   <= row_c;
						idx_q   <= '0;
						ph_q    <= 1'b0;
						state_q <= S_VOICE;
					end
				end
				S_VOICE: begin
					if (go) begin
						if (voice_on && !ph_q && !cfg.accomp_mode) begin
							ph_q <= 1'b1;
						end else begin
							ph_q          <= 1'b0;
							slot_q[idx_q] <= voice_on ? voice_v : 8'd0;
							if (idx_end)
								state_q <= S_IDLE;
							else
								idx_q <= idx_q + IW'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b00000, res_q.tag, res_q.lit, res_q.value, res_q.note, res_q.status};
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.last;

	a_last_is_ind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && res_q.last) |-> res_q.kind == RK_IND)
		else $error("final word of an item is not an indicator");

	a_tick_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TICK && cnt_q != 4'd0 && slot_q[0] != 8'd0) |=>
			cnt_q == $past(cnt_q) - 4'd1)
		else $error("tick did not decrement the countdown");

	a_voice_expired: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_VOICE |-> cnt_q == 4'd0)
		else $error("chord voiced before countdown expired");

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb: split keyboard chord detector testbench
// Drives key and tick words into the input stream with random gaps, collects
// result words under random back-pressure, and checks each one in order
// against a cycle-free model of the split, pass-through, overlay and
// one-finger chord logic. A few directed words come first, then chord
// sequences and loose noise under several register settings.
// ----------------------------------------------------------------------------
module tb;
	import skcd_pkg::*;

	// one result word as the model expects it
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] status;
		logic [7:0] note;
		logic [6:0] value;
		logic       lit;
		logic [2:0] tag;
		logic       last;
	} chord_out_t;

	// keyboard state model plus in-order result check
	class chord_tracker;
		localparam int NSLOT = SLOTS_DEF;

		bit         chord_on   = 1'b0;
		bit         accomp_on  = 1'b0;
		bit         overlay_on = 1'b0;
		bit [6:0]   split_at   = 7'd60;
		bit [3:0]   hold_len   = 4'd5;
		bit [7:0]   slots [NSLOT];
		bit [6:0]   held_vel   = 7'd0;
		bit [3:0]   countdown  = 4'd0;
		chord_out_t results_due [$];
		chord_out_t batch [$];
		int         errors     = 0;
		int         effective  = 0;

		function void write_reg(cfg_idx_t idx, bit [6:0] v);
			case (idx)
				CFG_CHORD_ACTIVE:  chord_on   = v[0];
				CFG_ACCOMP_MODE:   accomp_on  = v[0];
				CFG_RIGHT_OVERLAY: overlay_on = v[0];
				CFG_SPLIT_KEY:     split_at   = v;
				CFG_HOLD_TICKS:    hold_len   = v[3:0];
				default: ;
			endcase
		endfunction

		function void push(rk_t k, bit [7:0] st, bit [7:0] nt, bit [6:0] v, bit lt,
			bit [2:0] tg);
			chord_out_t r;
			r.kind   = k;
			r.status = st;
			r.note   = nt;
			r.value  = v;
			r.lit    = lt;
			r.tag    = tg;
			r.last   = 1'b0;
			batch.push_back(r);
		endfunction

		// pitch class of the low seven bits, also for slots above 127
		function bit [3:0] pitch_of(bit [7:0] code);
			return 4'(code[6:0] % 7'd12);
		endfunction

		function bit on_black(bit [7:0] code);
			bit blk;
			case (pitch_of(code)) inside
				4'd1, 4'd3, 4'd6, 4'd8, 4'd10: blk = 1'b1;
				default: blk = 1'b0;
			endcase
			return blk;
		endfunction

		// semitone offset of a chord row at a slot position
		function bit [3:0] chord_step(bit [1:0] row, int i);
			bit [3:0] s;
			case (i)
				1: s = (row == ROW_MAJ || row == ROW_SEV) ? 4'd4 : 4'd3;
				2: s = 4'd7;
				3: s = (row == ROW_MIN7 || row == ROW_SEV) ? 4'd10 : 4'd0;
				default: s = 4'd0;
			endcase
			return s;
		endfunction

		// countdown tick; on expiry sort top three, pick the chord, voice or report
		function void run_detect();
			bit [7:0] t;
			bit [6:0] ctype;
			bit [1:0] row;
			bit [3:0] step;
			if (countdown == 0 || slots[0] == 0)
				return;
			countdown = countdown - 4'd1;
			if (countdown != 0)
				return;
			if (slots[0] < slots[1]) begin
				t = slots[0]; slots[0] = slots[1]; slots[1] = t;
			end
			if (slots[1] < slots[2]) begin
				t = slots[1]; slots[1] = slots[2]; slots[2] = t;
			end
			if (slots[0] < slots[1]) begin
				t = slots[0]; slots[0] = slots[1]; slots[1] = t;
			end
			if (slots[1] == 0) begin
				ctype = CT_MAJ; row = ROW_MAJ;
			end else if (slots[2] != 0) begin
				ctype = CT_MIN7; row = ROW_MIN7;
			end else if (on_black(slots[1])) begin
				ctype = CT_MIN; row = ROW_MIN;
			end else begin
				ctype = CT_SEV; row = ROW_SEV;
			end
			if (accomp_on)
				push(RK_CHORD, 8'd0, {4'd0, pitch_of(slots[0])}, ctype, 1'b0, 3'd0);
			for (int i = 0; i < NSLOT; i++) begin
				step = chord_step(row, i);
				if (i == 0 || step != 0) begin
					slots[i] = slots[0] + {4'd0, step};
					if (!accomp_on)
						push(RK_NOTE, STAT_NOTE_C2, slots[i], held_vel, 1'b0, 3'd0);
					push(RK_IND, 8'd0, slots[i], 7'd0, 1'b1, TAG_CHORD);
				end else begin
					slots[i] = 8'd0;
				end
			end
		endfunction

		// left key in chord mode: fill a slot, or clear all on release
		function void left_chord(bit [7:0] st, bit [6:0] key, bit [6:0] vel);
			bit placed;
			placed = 1'b0;
			if (vel != 0 && st[4]) begin
				held_vel = vel;
				for (int i = 0; i < NSLOT; i++) begin
					if (!placed && slots[i] == 0) begin
						slots[i]  = {1'b0, key};
						countdown = hold_len;
						placed    = 1'b1;
					end
				end
			end else if (slots[0] != 0 || !st[4]) begin
				for (int i = 0; i < NSLOT; i++) begin
					if (slots[i] != 0) begin
						if (!accomp_on)
							push(RK_NOTE, STAT_NOTE_C2, slots[i], 7'd0, 1'b0, 3'd0);
						push(RK_IND, 8'd0, slots[i], 7'd0, 1'b0, TAG_CHORD);
					end
					slots[i] = 8'd0;
				end
			end
		endfunction

		// accepted input word: update state, queue the results it causes
		function void take_word(bit kind, bit [7:0] st, bit [6:0] key, bit [6:0] vel);
			bit [2:0] cmd;
			bit       sys_reset;
			batch.delete();
			cmd       = st[6:4];
			sys_reset = (st == STAT_SYS_A || st == STAT_SYS_B) && key == 0 && vel == 0;
			if (kind) begin
				effective++;
				if (chord_on)
					run_detect();
			end else if (!sys_reset && (cmd == CMD_RELEASE || cmd == CMD_PRESS)) begin
				effective++;
				if (key < split_at) begin
					if (chord_on)
						left_chord(st, key, vel);
					else if (!accomp_on)
						push(RK_NOTE, {st[7:4], CHAN_1}, {1'b0, key}, vel, 1'b0, 3'd0);
				end else begin
					push(RK_NOTE, st, {1'b0, key}, vel, 1'b0, 3'd0);
					if (overlay_on)
						push(RK_NOTE, {st[7:4], CHAN_2}, {1'b0, key}, vel, 1'b0, 3'd0);
				end
				push(RK_IND, 8'd0, {1'b0, key}, 7'd0, vel != 0, TAG_KEY);
			end
			if (batch.size() > 0)
				batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i])
				results_due.push_back(batch[i]);
		endfunction

		// fields of a result word, in port order
		function string describe(chord_out_t r);
			return $sformatf("kind %0d st %02h note %0d val %0d lit %0d tag %0d last %0d",
				r.kind, r.status, r.note, r.value, r.lit, r.tag, r.last);
		endfunction

		// accepted result word against the oldest expectation
		function void check_word(logic [1:0] kind, logic [M_DATA_W-1:0] data, logic last);
			chord_out_t got;
			chord_out_t want;
			got.kind   = kind;
			got.status = data[7:0];
			got.note   = data[15:8];
			got.value  = data[22:16];
			got.lit    = data[23];
			got.tag    = data[26:24];
			got.last   = last;
			if (results_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, actual %s",
					$time, describe(got));
				return;
			end
			want = results_due.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: mismatch, expected %s, actual %s",
					$time, describe(want), describe(got));
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	chord_tracker chords = new();
	// no idling on either side while set
	bit           calm = 1'b0;

	split_keyboard_chord_detector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5000000;
		$display("tb: errors");
		$finish;
	end

	// one input word: random gap, then hold until accepted
	task automatic send_word(input bit kind, input bit [7:0] st, input bit [6:0] key,
		input bit [6:0] vel);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= S_DATA_W'({vel, key, st});
		@(posedge clk);
		while (s_tready !== 1'b1) @(posedge clk);
		chords.take_word(kind, st, key, vel);
	endtask

	task automatic put_reg(input cfg_idx_t idx, input bit [6:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		chords.write_reg(idx, v);
		@(posedge clk);
	endtask

	// unused upper bits of narrow registers get random fill
	task automatic set_config(input bit ca, input bit am, input bit ro, input bit [6:0] sk,
		input bit [3:0] ht);
		put_reg(CFG_CHORD_ACTIVE, {6'($urandom), ca});
		put_reg(CFG_ACCOMP_MODE, {6'($urandom), am});
		put_reg(CFG_RIGHT_OVERLAY, {6'($urandom), ro});
		put_reg(CFG_SPLIT_KEY, sk);
		put_reg(CFG_HOLD_TICKS, {3'($urandom), ht});
		cfg_we <= 1'b0;
	endtask

	// wait for every expected word, then let queued silent commands finish
	task automatic settle();
		s_tvalid <= 1'b0;
		while (chords.results_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic tick();
		send_word(1'b1, 8'($urandom), 7'($urandom), 7'($urandom));
	endtask

	task automatic right_key();
		bit [7:0] st;
		st = {1'($urandom), 2'b00, 1'($urandom), 4'($urandom)};
		send_word(1'b0, st, 7'($urandom_range(chords.split_at, 127)), 7'($urandom));
	endtask

	task automatic press_left();
		bit [7:0] st;
		bit [6:0] vel;
		st  = {1'($urandom_range(0, 3) != 0), 3'b001, 4'($urandom)};
		vel = ($urandom_range(0, 7) == 0) ? 7'd127 : 7'($urandom_range(1, 127));
		if (chords.split_at == 0)
			right_key();
		else
			send_word(1'b0, st, 7'($urandom_range(0, chords.split_at - 1)), vel);
	endtask

	// release as a release command, or as a press with zero velocity
	task automatic release_left();
		bit [7:0] st;
		bit [6:0] vel;
		if ($urandom_range(0, 3) == 0) begin
			st  = {1'($urandom), 3'b001, 4'($urandom)};
			vel = 7'd0;
		end else begin
			st  = {1'($urandom), 3'b000, 4'($urandom)};
			vel = 7'($urandom);
		end
		if (chords.split_at == 0)
			right_key();
		else
			send_word(1'b0, st, 7'($urandom_range(0, chords.split_at - 1)), vel);
	endtask

	task automatic loose_item();
		case ($urandom_range(0, 5))
			0: tick();
			1: press_left();
			2: release_left();
			3: right_key();
			4: send_word(1'($urandom), 8'($urandom), 7'($urandom), 7'($urandom));
			default: send_word(1'b0, $urandom_range(0, 1) ? STAT_SYS_A : STAT_SYS_B, 7'd0, 7'd0);
		endcase
	endtask

	// presses, countdown ticks, mostly a release; skipped release stacks chords
	task automatic chord_run();
		int n;
		int ticks;
		n = $urandom_range(1, SLOTS_DEF + 1);
		repeat (n) begin
			press_left();
			if ($urandom_range(0, 4) == 0)
				loose_item();
		end
		ticks = chords.hold_len + $urandom_range(0, 2);
		repeat (ticks) begin
			tick();
			if ($urandom_range(0, 7) == 0)
				right_key();
		end
		if ($urandom_range(0, 9) < 7)
			release_left();
	endtask

	// result side: random stall before each word
	initial begin
		int gap;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 11);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (m_tvalid !== 1'b1) @(posedge clk);
			chords.check_word(m_tuser, m_tdata, m_tlast);
		end
	end

	// stimulus
	initial begin
		int goal;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_CHORD_ACTIVE;
		cfg_data  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: split, pass-through, ignored commands, idle tick
		send_word(1'b0, 8'h9F, 7'd127, 7'd127);
		send_word(1'b0, 8'h8F, 7'd60, 7'd0);
		send_word(1'b0, 8'h95, 7'd59, 7'd1);
		send_word(1'b0, 8'h00, 7'd0, 7'd64);
		send_word(1'b0, STAT_SYS_A, 7'd0, 7'd0);
		send_word(1'b0, STAT_SYS_B, 7'd0, 7'd0);
		send_word(1'b0, 8'hF0, 7'd10, 7'd10);
		send_word(1'b1, 8'hFF, 7'd127, 7'd127);
		settle();

		// muted left part, overlay copy of right keys
		set_config(1'b0, 1'b1, 1'b1, 7'd127, 4'd15);
		send_word(1'b0, 8'h93, 7'd126, 7'd100);
		send_word(1'b0, 8'h9A, 7'd127, 7'd5);
		settle();

		// voiced chords: seventh, stacked min7 from a second detection
		set_config(1'b1, 1'b0, 1'b0, 7'd127, 4'd1);
		send_word(1'b0, 8'h90, 7'd48, 7'd90);
		send_word(1'b0, 8'h10, 7'd50, 7'd70);
		tick();
		send_word(1'b0, 8'h91, 7'd0, 7'd33);
		tick();
		send_word(1'b0, 8'h90, 7'd20, 7'd0);
		// full slots: sixth press only updates the velocity
		send_word(1'b0, 8'h90, 7'd40, 7'd11);
		send_word(1'b0, 8'h90, 7'd41, 7'd22);
		send_word(1'b0, 8'h90, 7'd42, 7'd33);
		send_word(1'b0, 8'h90, 7'd43, 7'd44);
		send_word(1'b0, 8'h90, 7'd44, 7'd55);
		send_word(1'b0, 8'h90, 7'd45, 7'd66);
		tick();
		send_word(1'b0, 8'h80, 7'd40, 7'd0);
		settle();

		// zero hold: press never arms a detection
		set_config(1'b1, 1'b1, 1'b0, 7'd127, 4'd0);
		send_word(1'b0, 8'h9C, 7'd61, 7'd80);
		tick();
		settle();

		// accompaniment report: a single black key gives major
		set_config(1'b1, 1'b1, 1'b1, 7'd64, 4'd2);
		send_word(1'b0, 8'h9C, 7'd49, 7'd80);
		tick();
		tick();
		settle();

		// random phases
		for (int p = 0; p < 8; p++) begin
			calm = (p % 3 == 2);
			case (p)
				0: set_config(1'b1, 1'($urandom), 1'($urandom), 7'd127, 4'd1);
				1: set_config(1'b1, 1'($urandom), 1'b1, 7'd0, 4'd15);
				2: set_config(1'b1, 1'b0, 1'($urandom), 7'($urandom_range(30, 90)), 4'd15);
				3: set_config(1'b0, 1'($urandom), 1'($urandom), 7'($urandom_range(1, 126)), 4'd3);
				default: set_config(p % 4 != 3, 1'($urandom), 1'($urandom),
					7'($urandom_range(1, 126)), 4'($urandom_range(1, 15)));
			endcase
			goal = chords.effective + 44;
			while (chords.effective < goal) begin
				if ($urandom_range(0, 9) < 7)
					chord_run();
				else
					loose_item();
			end
			settle();
		end

		if (chords.errors == 0 && chords.results_due.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule

FILE: split_keyboard_chord_detector.f
rtl/skcd_pkg.sv
rtl/skcd_front.sv
rtl/skcd_fifo.sv
rtl/skcd_back.sv
rtl/split_keyboard_chord_detector.sv
test/tb.sv
